/* rtl/hcbd_pkg.sv */
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int SizeW = 32;
    localparam int LenW  = 48;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_start;
    } t_in_item;

    typedef struct packed {
        logic            payload_valid;
        logic [7:0]      payload_byte;
        logic            chunk_end;
        logic            body_done;
        logic            format_error;
        logic [LenW-1:0] body_length;
    } t_out_item;

    typedef struct packed {
        t_phase           phase;
        logic [SizeW-1:0] remaining;
        logic [LenW-1:0]  total;
        logic             error;
    } t_state;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    localparam t_state StateReset = '{
        phase:     PH_SIZE,
        remaining: '0,
        total:     '0,
        error:     1'b0
    };

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.value = c[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: h.value = 4'(c[3:0] + 4'd9);
            default:       h.ok = 1'b0;
        endcase
        return h;
    endfunction

endpackage

/* rtl/hcbd_if.sv */
`timescale 1ns / 1ps

interface hcbd_in_if;
    import hcbd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcbd_out_if;
    import hcbd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/hcbd_step.sv */
`timescale 1ns / 1ps

module hcbd_step
    import hcbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 8,
    localparam int DigitW = $clog2(MAX_SIZE_DIGITS + 1)
) (
    input  t_in_item          i_item,
    input  t_state            i_state,
    input  logic [DigitW-1:0] i_digits,
    output t_state            o_state,
    output logic [DigitW-1:0] o_digits,
    output t_out_item         o_result
);

    t_state            cur;
    logic [DigitW-1:0] cur_digits;
    t_hex              hex;

    // body_start restarts the decoder before this byte
    always_comb begin
        cur        = i_item.body_start ? StateReset : i_state;
        cur_digits = i_item.body_start ? '0 : i_digits;
        hex        = hex_decode(i_item.body_byte);
    end

    always_comb begin
        o_state  = cur;
        o_digits = cur_digits;
        case (cur.phase)
            PH_SIZE: begin
                if (hex.ok) begin
                    if (cur_digits >= DigitW'(MAX_SIZE_DIGITS)) begin
                        o_state.phase = PH_ERROR;
                        o_state.error = 1'b1;
                    end else begin
                        o_state.remaining = {cur.remaining[SizeW-5:0], hex.value};
                        o_digits          = cur_digits + 1'b1;
                    end
                end else if (i_item.body_byte == CH_CR && cur_digits != '0) begin
                    o_state.phase = PH_SIZE_LF;
                end else begin
                    o_state.phase = PH_ERROR;
                    o_state.error = 1'b1;
                end
            end
            PH_SIZE_LF: begin
                if (i_item.body_byte != CH_LF) begin
                    o_state.phase = PH_ERROR;
                    o_state.error = 1'b1;
                end else if (cur.remaining == '0) begin
                    o_state.phase = PH_DONE;
                end else begin
                    o_state.phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (cur.total != '1) begin
                    o_state.total = cur.total + 1'b1;
                end
                o_state.remaining = cur.remaining - 1'b1;
                if (cur.remaining == SizeW'(1)) begin
                    o_state.phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_item.body_byte == CH_CR) begin
                    o_state.phase = PH_DATA_LF;
                end else begin
                    o_state.phase = PH_ERROR;
                    o_state.error = 1'b1;
                end
            end
            PH_DATA_LF: begin
                if (i_item.body_byte == CH_LF) begin
                    o_state.phase     = PH_SIZE;
                    o_state.remaining = '0;
                    o_digits          = '0;
                end else begin
                    o_state.phase = PH_ERROR;
                    o_state.error = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
                o_state.phase = PH_ERROR;
                o_state.error = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_result.payload_valid = (cur.phase == PH_DATA);
        o_result.payload_byte  = (cur.phase == PH_DATA) ? i_item.body_byte : 8'd0;
        o_result.chunk_end     = (cur.phase == PH_DATA) && (cur.remaining == SizeW'(1));
        o_result.body_done     = (o_state.phase == PH_DONE);
        o_result.format_error  = o_state.error;
        o_result.body_length   = o_state.total;
    end

endmodule

/* rtl/http_chunked_body_decoder_top.sv */
`timescale 1ns / 1ps
// channel   dir  payload                                        transfer
// i_body    in   body_byte, body_start                          valid & ready
// o_result  out  payload_valid, payload_byte, chunk_end,        valid & ready
//                body_done, format_error, body_length
//
// one byte per cycle sustained while o_result.ready stays high; each byte passes
// through the input register and leaves through the result register
// decoder state advances when a byte moves from the input to the result register
// synchronous active-low reset clears both valid flags and the decoder state
// a stalled result holds the input register, i_body.ready drops once it is full

module http_chunked_body_decoder_top
    import hcbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbd_in_if.sink           i_body,
    hcbd_out_if.source        o_result
);

    localparam int DigitW = $clog2(MAX_SIZE_DIGITS + 1);

    logic              r_in_valid;
    t_in_item          r_in_item;
    t_state            r_state;
    logic [DigitW-1:0] r_digits;
    logic              r_out_valid;
    t_out_item         r_out_item;

    t_state            n_state;
    logic [DigitW-1:0] n_digits;
    t_out_item         n_out_item;
    logic              advance;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_body.ready   = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_item;

    hcbd_step #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .i_digits (r_digits),
        .o_state  (n_state),
        .o_digits (n_digits),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= StateReset;
            r_digits    <= '0;
        end else begin
            if (i_body.ready) begin
                r_in_valid <= i_body.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_digits    <= n_digits;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_body.ready && i_body.valid) begin
            r_in_item <= i_body.data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

/* rtl/hcbd_checker.sv */
`timescale 1ns / 1ps

module hcbd_checker
    import hcbd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // a result waiting for its transfer is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before transfer");

    a_chunk_end_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.chunk_end |-> i_out_data.payload_valid)
        else $error("chunk end without payload byte");

    // no payload once the body is finished or broken
    a_payload_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.payload_valid
            |-> !i_out_data.format_error && !i_out_data.body_done)
        else $error("payload byte after done or error");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
